/* rtl/msl_pkg.sv */
// Shared types and constants for the music score lexer.
package msl_pkg;

  // Token kinds as they appear on the result stream
  typedef enum logic [3:0] {
    KIND_LBRACKET = 4'd0,
    KIND_RBRACKET = 4'd1,
    KIND_LBRACE   = 4'd2,
    KIND_RBRACE   = 4'd3,
    KIND_EQUALS   = 4'd4,
    KIND_NOTES    = 4'd5,
    KIND_PCM      = 4'd6,
    KIND_NUMBER   = 4'd7,
    KIND_NOTE     = 4'd8,
    KIND_STRING   = 4'd9
  } token_kind_t;

  // Progress through the note grammar
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_DIGITS = 3'd1,
    PH_NEED1  = 3'd2,
    PH_NEED2  = 3'd3,
    PH_OK     = 3'd4,
    PH_BAD    = 3'd5
  } note_phase_t;

  // Keyword match progress; KW_DEAD means the keyword no longer matches
  localparam logic [2:0] KW_DEAD   = 3'd7;
  localparam logic [2:0] NOTES_LEN = 3'd5;
  localparam logic [2:0] PCM_LEN   = 3'd3;

  // One queue entry: up to two results caused by one input request
  typedef struct packed {
    logic        has_word;
    token_kind_t word_kind;
    logic [7:0]  word_len;
    logic        has_punct;
    token_kind_t punct_kind;
  } q_entry_t;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

endpackage

/* rtl/msl_front.sv */
// Front part: accepts characters, tracks the pending word and classifies it.
module msl_front
  import msl_pkg::*;
#(
  parameter int unsigned MAX_WORD_LEN = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       end_of_input,
  input  q_status_t  q_status,
  output logic       push,
  output q_entry_t   push_entry
);

  localparam int unsigned CAP = (MAX_WORD_LEN < 255) ? MAX_WORD_LEN : 255;
  localparam logic [7:0] CAP8 = 8'(CAP);

  logic [7:0]  word_length, word_length_next;
  logic [2:0]  kw_notes, kw_notes_next;
  logic [2:0]  kw_pcm, kw_pcm_next;
  logic        all_digits, all_digits_next;
  note_phase_t note_phase, note_phase_next;

  logic        accept;
  logic        is_sep;
  logic        punct_hit;
  token_kind_t punct_kind;
  logic        dig;
  logic        ends_word;
  token_kind_t word_kind;
  logic [7:0]  notes_char;
  logic [7:0]  pcm_char;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // Character classes
  always_comb begin
    is_sep     = 1'b0;
    punct_hit  = 1'b0;
    punct_kind = KIND_LBRACKET;
    case (ch) inside
      8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h2C: is_sep = 1'b1;
      8'h5B: begin punct_hit = 1'b1; punct_kind = KIND_LBRACKET; end
      8'h5D: begin punct_hit = 1'b1; punct_kind = KIND_RBRACKET; end
      8'h7B: begin punct_hit = 1'b1; punct_kind = KIND_LBRACE;   end
      8'h7D: begin punct_hit = 1'b1; punct_kind = KIND_RBRACE;   end
      8'h3D: begin punct_hit = 1'b1; punct_kind = KIND_EQUALS;   end
      default: ;
    endcase
    dig = (ch >= 8'h30) && (ch <= 8'h39);
  end

  // Expected next keyword characters
  always_comb begin
    case (kw_notes)
      3'd0:    notes_char = 8'h4E;  // N
      3'd1:    notes_char = 8'h4F;  // O
      3'd2:    notes_char = 8'h54;  // T
      3'd3:    notes_char = 8'h45;  // E
      3'd4:    notes_char = 8'h53;  // S
      default: notes_char = 8'h00;
    endcase
    case (kw_pcm)
      3'd0:    pcm_char = 8'h50;    // P
      3'd1:    pcm_char = 8'h43;    // C
      3'd2:    pcm_char = 8'h4D;    // M
      default: pcm_char = 8'h00;
    endcase
  end

  // Classification of the pending word
  always_comb begin
    if (kw_notes == NOTES_LEN)      word_kind = KIND_NOTES;
    else if (kw_pcm == PCM_LEN)     word_kind = KIND_PCM;
    else if (all_digits)            word_kind = KIND_NUMBER;
    else if (note_phase == PH_OK)   word_kind = KIND_NOTE;
    else                            word_kind = KIND_STRING;
  end

  // Results for the queue
  always_comb begin
    ends_word             = end_of_input || is_sep || punct_hit;
    push_entry.has_word   = ends_word && (word_length != 8'd0);
    push_entry.word_kind  = word_kind;
    push_entry.word_len   = word_length;
    push_entry.has_punct  = !end_of_input && punct_hit;
    push_entry.punct_kind = punct_kind;
    push = accept && (push_entry.has_word || push_entry.has_punct);
  end

  // Next word state
  always_comb begin
    word_length_next = word_length;
    kw_notes_next    = kw_notes;
    kw_pcm_next      = kw_pcm;
    all_digits_next  = all_digits;
    note_phase_next  = note_phase;
    if (ends_word) begin
      word_length_next = 8'd0;
      kw_notes_next    = 3'd0;
      kw_pcm_next      = 3'd0;
      all_digits_next  = 1'b1;
      note_phase_next  = PH_START;
    end else begin
      if (word_length < CAP8) word_length_next = word_length + 8'd1;
      kw_notes_next = ((kw_notes < NOTES_LEN) && (ch == notes_char)) ?
                      kw_notes + 3'd1 : KW_DEAD;
      kw_pcm_next   = ((kw_pcm < PCM_LEN) && (ch == pcm_char)) ?
                      kw_pcm + 3'd1 : KW_DEAD;
      if (!dig) all_digits_next = 1'b0;
      case (note_phase)
        PH_START: note_phase_next = dig ? PH_DIGITS : PH_BAD;
        PH_DIGITS: begin
          if (dig)                                 note_phase_next = PH_DIGITS;
          else if ((ch >= 8'h41) && (ch <= 8'h48)) note_phase_next = PH_NEED1;
          else if (ch == 8'h2D)                    note_phase_next = PH_OK;
          else                                     note_phase_next = PH_BAD;
        end
        PH_NEED1: note_phase_next = ((ch == 8'h23) || (ch == 8'h62)) ? PH_NEED2 : PH_OK;
        PH_NEED2: note_phase_next = PH_OK;
        PH_OK:    note_phase_next = PH_OK;
        default:  note_phase_next = PH_BAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length <= 8'd0;
      kw_notes    <= 3'd0;
      kw_pcm      <= 3'd0;
      all_digits  <= 1'b1;
      note_phase  <= PH_START;
    end else if (accept) begin
      word_length <= word_length_next;
      kw_notes    <= kw_notes_next;
      kw_pcm      <= kw_pcm_next;
      all_digits  <= all_digits_next;
      note_phase  <= note_phase_next;
    end
  end

endmodule

/* rtl/msl_queue.sv */
// Short queue of result groups between the front and back parts.
module msl_queue
  import msl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t status
);

  q_entry_t          entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign status.not_empty = (count != '0);
  assign status.full      = (count == (QPTR_W + 1)'(QDEPTH));
  assign head             = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/msl_back.sv */
// Back part: splits queued result groups into single results on an output register.
module msl_back
  import msl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  q_entry_t    head,
  input  q_status_t   q_status,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output token_kind_t out_kind,
  output logic [7:0]  out_len,
  output logic        out_last
);

  logic        out_valid_next;
  token_kind_t out_kind_next;
  logic [7:0]  out_len_next;
  logic        out_last_next;
  logic        second, second_next;
  logic        load;

  // Choose the next result to place on the output register
  always_comb begin
    load           = !out_valid || out_ready;
    pop            = 1'b0;
    out_valid_next = out_valid;
    out_kind_next  = out_kind;
    out_len_next   = out_len;
    out_last_next  = out_last;
    second_next    = second;
    if (load) begin
      if (second) begin
        out_valid_next = 1'b1;
        out_kind_next  = head.punct_kind;
        out_len_next   = 8'd1;
        out_last_next  = 1'b1;
        second_next    = 1'b0;
        pop            = 1'b1;
      end else if (q_status.not_empty) begin
        out_valid_next = 1'b1;
        if (head.has_word) begin
          out_kind_next = head.word_kind;
          out_len_next  = head.word_len;
          out_last_next = !head.has_punct;
          if (head.has_punct) second_next = 1'b1;
          else                pop = 1'b1;
        end else begin
          out_kind_next = head.punct_kind;
          out_len_next  = 8'd1;
          out_last_next = 1'b1;
          pop           = 1'b1;
        end
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      second    <= second_next;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    out_kind <= out_kind_next;
    out_len  <= out_len_next;
    out_last <= out_last_next;
  end

endmodule

/* rtl/music_score_lexer.sv */
// Top level of the music score lexer: front, queue and back parts.
//
// Input stream (s_*): one character request per accepted beat; s_tlast marks
// end of input, in which case s_tdata is ignored, any pending word is flushed
// and the word state returns to its reset value.
// Output stream (m_*): one token per beat, kind and length; m_tlast is set on
// the last token caused by one input request (a word followed by punctuation
// gives two tokens, the word first).
// Throughput: one character per cycle while the queue is not full. A request
// that yields two tokens puts them on the output one after the other; the
// four-entry queue between the character front end and the output stage
// absorbs these bursts. A token that a request ends is written into the queue,
// then loaded into the output register from there when the output is free.
// Reset (rst, synchronous) empties the queue and output and clears the word.
// When the receiver stalls, the output register holds its token, the queue
// fills, and s_tready drops once the queue is full.
module music_score_lexer
  import msl_pkg::*;
#(
  parameter int unsigned MAX_WORD_LEN = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] token_kind, [11:4] token_length, [15:12] zero
  output logic        m_tlast    // last
);

  logic        push;
  q_entry_t    push_entry;
  logic        pop;
  q_entry_t    head;
  q_status_t   q_status;
  token_kind_t out_kind;
  logic [7:0]  out_len;

  // Character front end
  msl_front #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .ch           (s_tdata),
    .end_of_input (s_tlast),
    .q_status     (q_status),
    .push         (push),
    .push_entry   (push_entry)
  );

  // Result group queue
  msl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // Output stage
  msl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (out_kind),
    .out_len   (out_len),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'b0000, out_len, out_kind};

endmodule

/* tb/tb.sv */
// Self-checking testbench for music_score_lexer: character requests in, tokens checked out.
module tb
  import msl_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEN    = 255;
  localparam int unsigned LEN_CAP    = (MAX_LEN < 255) ? MAX_LEN : 255;
  localparam int unsigned RAND_ITEMS = 700;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned DRAIN      = 20;

  localparam logic [39:0] NOTES_TXT = "NOTES";
  localparam logic [23:0] PCM_TXT   = "PCM";

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } char_req_t;

  typedef struct {
    token_kind_t kind;
    logic [7:0]  len;
    logic        last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  char_req_t pending_chars[$];
  token_t    expected_tokens[$];
  bit        failed = 1'b0;
  logic      req_taken = 1'b0;
  int        idle_cycles = 0;

  // Shadow of the lexer's word state
  logic [7:0]  w_len;
  logic [2:0]  notes_prog;
  logic [2:0]  pcm_prog;
  logic        digits_only;
  note_phase_t phase;

  music_score_lexer #(.MAX_WORD_LEN(MAX_LEN)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  function automatic bit is_sep(input logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
           c == 8'h0C || c == 8'h0D || c == ",";
  endfunction

  function automatic bit punct_of(input logic [7:0] c, output token_kind_t k);
    k = KIND_STRING;
    case (c)
      "[": k = KIND_LBRACKET;
      "]": k = KIND_RBRACKET;
      "{": k = KIND_LBRACE;
      "}": k = KIND_RBRACE;
      "=": k = KIND_EQUALS;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Keyword matcher step; text is right-aligned, first character highest
  function automatic logic [2:0] kw_next(input logic [2:0] prog, input logic [39:0] txt,
                                         input logic [2:0] len, input logic [7:0] c);
    if (prog >= len) return KW_DEAD;
    return (txt[8 * (int'(len) - 1 - int'(prog)) +: 8] == c) ? prog + 3'd1 : KW_DEAD;
  endfunction

  function automatic token_kind_t word_class();
    if (notes_prog == NOTES_LEN) return KIND_NOTES;
    if (pcm_prog == PCM_LEN) return KIND_PCM;
    if (digits_only) return KIND_NUMBER;
    if (phase == PH_OK) return KIND_NOTE;
    return KIND_STRING;
  endfunction

  task automatic clear_word();
    w_len       = 8'd0;
    notes_prog  = 3'd0;
    pcm_prog    = 3'd0;
    digits_only = 1'b1;
    phase       = PH_START;
  endtask

  task automatic add_token(input token_kind_t k, input logic [7:0] len);
    token_t t;
    t.kind = k;
    t.len  = len;
    t.last = 1'b0;
    expected_tokens.push_back(t);
  endtask

  task automatic absorb_char(input logic [7:0] c);
    bit dig;
    dig = is_digit(c);
    if (w_len < LEN_CAP) w_len = w_len + 8'd1;
    notes_prog = kw_next(notes_prog, NOTES_TXT, NOTES_LEN, c);
    pcm_prog   = kw_next(pcm_prog, {16'h0, PCM_TXT}, PCM_LEN, c);
    if (!dig) digits_only = 1'b0;
    case (phase)
      PH_START:  phase = dig ? PH_DIGITS : PH_BAD;
      PH_DIGITS: begin
        if (dig) phase = PH_DIGITS;
        else if (c >= "A" && c <= "H") phase = PH_NEED1;
        else if (c == "-") phase = PH_OK;
        else phase = PH_BAD;
      end
      PH_NEED1:  phase = (c == "#" || c == "b") ? PH_NEED2 : PH_OK;
      PH_NEED2:  phase = PH_OK;
      PH_OK:     phase = PH_OK;
      default:   phase = PH_BAD;
    endcase
  endtask

  // Expected tokens for one accepted character request
  task automatic lex_request(input logic [7:0] c, input logic eoi);
    int          n_before;
    token_kind_t pk;
    bit          is_p;
    n_before = expected_tokens.size();
    is_p = punct_of(c, pk);
    if (eoi || is_sep(c) || is_p) begin
      if (w_len > 0) add_token(word_class(), w_len);
      clear_word();
      if (!eoi && is_p) add_token(pk, 8'd1);
    end else begin
      absorb_char(c);
    end
    if (expected_tokens.size() > n_before)
      expected_tokens[expected_tokens.size() - 1].last = 1'b1;
  endtask

  // Stimulus helpers
  task automatic push_char(input logic [7:0] c, input logic eoi = 1'b0);
    char_req_t r;
    r.ch  = c;
    r.eoi = eoi;
    pending_chars.push_back(r);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  function automatic logic [7:0] word_byte();
    logic [7:0]  c;
    token_kind_t k;
    do c = 8'($urandom_range(0, 255)); while (is_sep(c) || punct_of(c, k));
    return c;
  endfunction

  function automatic logic [7:0] sep_byte();
    logic [7:0] seps[7] = '{" ", 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, ","};
    return seps[$urandom_range(0, 6)];
  endfunction

  function automatic logic [7:0] punct_byte();
    logic [7:0] p[5] = '{"[", "]", "{", "}", "="};
    return p[$urandom_range(0, 4)];
  endfunction

  function automatic logic [7:0] digit_byte();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  task automatic push_word();
    string kw[10] = '{"NOTES", "PCM", "NOTE", "NOTESS", "PC", "PCMM", "NOTEX", "PCX",
                      "notes", "N"};
    int    r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      push_text(kw[$urandom_range(0, 9)]);
    end else if (r < 30) begin
      repeat ($urandom_range(1, 6)) push_char(digit_byte());
    end else if (r < 60) begin
      // note shape: digits, a letter or dash, then a short tail
      repeat ($urandom_range(1, 4)) push_char(digit_byte());
      case ($urandom_range(0, 9))
        0, 1:    push_char("-");
        2:       push_char(8'("I" + $urandom_range(0, 3)));
        default: push_char(8'("A" + $urandom_range(0, 7)));
      endcase
      if ($urandom_range(0, 2) == 0) push_char($urandom_range(0, 1) ? "#" : "b");
      repeat ($urandom_range(0, 2)) push_char(word_byte());
    end else if (r < 85) begin
      repeat ($urandom_range(1, 8)) push_char(word_byte());
    end else begin
      // noise: any byte, separators and punctuation included
      repeat ($urandom_range(1, 5)) push_char(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic push_break();
    int r;
    repeat ($urandom_range(1, 3) == 3 ? 2 : 1) begin
      r = $urandom_range(0, 99);
      if (r < 55) push_char(sep_byte());
      else if (r < 85) push_char(punct_byte());
      else push_char(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic push_long_word(input bit digits);
    repeat ($urandom_range(255, 280)) push_char(digits ? digit_byte() : word_byte());
    push_break();
  endtask

  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Request side: drive at the falling edge, hold until taken
  int tx_gap = 0;
  bit tx_quiet = 1'b0;
  always @(negedge clk) begin
    char_req_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !req_taken) begin
      s_tvalid <= 1'b1;
    end else if (tx_gap > 0) begin
      tx_gap = tx_gap - 1;
      s_tvalid <= 1'b0;
    end else if (pending_chars.size() > 0) begin
      r = pending_chars.pop_front();
      s_tvalid <= 1'b1;
      s_tdata  <= r.ch;
      s_tlast  <= r.eoi;
      if ($urandom_range(0, 99) < 3) tx_quiet = ~tx_quiet;
      tx_gap = (!tx_quiet && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Token side back-pressure
  int rx_stall = 0;
  bit rx_quiet = 1'b0;
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) rx_quiet = ~rx_quiet;
    if (rx_stall > 0) begin
      rx_stall = rx_stall - 1;
      m_tready <= 1'b0;
    end else if (!rst && !rx_quiet && $urandom_range(0, 3) == 0) begin
      rx_stall = pick_gap() - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Sample both sides at the rising edge: predict on requests, check on tokens
  always @(posedge clk) begin
    token_t exp_tok;
    req_taken <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) lex_request(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token: kind %0d, length %0d", m_tdata[3:0], m_tdata[11:4]);
          failed = 1'b1;
        end else begin
          exp_tok = expected_tokens.pop_front();
          if (m_tdata[3:0] !== exp_tok.kind) begin
            $error("token_kind: expected %0d, actual %0d", exp_tok.kind, m_tdata[3:0]);
            failed = 1'b1;
          end
          if (m_tdata[11:4] !== exp_tok.len) begin
            $error("token_length: expected %0d, actual %0d", exp_tok.len, m_tdata[11:4]);
            failed = 1'b1;
          end
          if (m_tlast !== exp_tok.last) begin
            $error("last: expected %0d, actual %0d", exp_tok.last, m_tlast);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_word();

    // Directed: keywords, number, notes, every punctuation, byte extremes,
    // end of input with and without a pending word, lone separator
    push_text("NOTES[");
    push_text("PCM]");
    push_text("12{");
    push_text("3A#x}");
    push_text("7-=");
    push_char(8'hFF);
    push_char(8'h00);
    push_char(8'hA5, 1'b1);
    push_char(8'h5A, 1'b1);
    push_char(" ");

    // Random words, with two saturating words part way through
    while (pending_chars.size() < RAND_ITEMS) begin
      if (pending_chars.size() > 100 && pending_chars.size() < 120) push_long_word(1'b1);
      if (pending_chars.size() > 400 && pending_chars.size() < 420) push_long_word(1'b0);
      push_word();
      push_break();
    end
    push_char(8'h00, 1'b1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() > 0 || s_tvalid) @(posedge clk);
    while (expected_tokens.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (!failed) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
